FILE: src/crev_pkg.sv
// ----------------------------------------------------------------------------
// crev_pkg: shared types and constants of the color ramp evaluator
// Field widths, mode and register codes, and the quarter-wave sine table.
// ----------------------------------------------------------------------------
package crev_pkg;

	localparam int CHAN_W     = 16;
	localparam int POS_W      = 16;
	localparam int U_W        = 16;
	localparam int UF_W       = 17;
	localparam int SINE_DEPTH = 256;

	localparam logic [UF_W-1:0] Q16_ONE = 17'h10000;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// register indexes
	localparam logic REG_POINT_COUNT = 1'b0;
	localparam logic REG_INTERP_MODE = 1'b1;

	// shaping modes
	localparam logic [2:0] MODE_NONE      = 3'd0;
	localparam logic [2:0] MODE_LINEAR    = 3'd1;
	localparam logic [2:0] MODE_EASE_UP   = 3'd2;
	localparam logic [2:0] MODE_EASE_DOWN = 3'd3;
	localparam logic [2:0] MODE_SMOOTH    = 3'd4;
	localparam logic [2:0] MODE_BUMP      = 3'd5;
	localparam logic [2:0] MODE_SPIKE     = 3'd6;

	typedef struct packed {
		logic [CHAN_W-1:0] r;
		logic [CHAN_W-1:0] g;
		logic [CHAN_W-1:0] b;
	} rgb_t;

	typedef struct packed {
		logic zero;
		logic up;
	} shape_ctl_t;

	typedef struct packed {
		shape_ctl_t ctl;
		rgb_t       c0;
		rgb_t       c1;
	} div_side_t;

	typedef logic [UF_W-1:0] sine_tab_t [0:SINE_DEPTH];

	// odd-power series divisors (2n)(2n+1)
	localparam logic [63:0] SERIES_DIV [0:6] = '{64'd6, 64'd20, 64'd42, 64'd72,
		64'd110, 64'd156, 64'd210};

	// taylor series to x^15 in q1.30, rounded half up to q1.16
	function automatic sine_tab_t build_sine();
		sine_tab_t   tab;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] v;
		for (int k = 0; k <= SINE_DEPTH; k++) begin
			x    = (HALF_PI_Q30 * 64'(k)) / SINE_DEPTH;
			x2   = (x * x) >> 30;
			term = x;
			sum  = x;
			for (int n = 1; n <= 7; n++) begin
				term = ((term * x2) >> 30) / SERIES_DIV[n-1];
				if (n % 2 == 1)
					sum = (sum >= term) ? sum - term : 64'd0;
				else
					sum = sum + term;
			end
			v = (sum + 64'd8192) >> 14;
			tab[k] = (v > 64'(Q16_ONE)) ? Q16_ONE : v[UF_W-1:0];
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine();

endpackage

FILE: src/crev_lookup_if.sv
// ----------------------------------------------------------------------------
// crev_lookup_if: input item channel
// Carries point writes and ramp evaluations with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface crev_lookup_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [2:0]  point_index;
	logic [15:0] point_position;
	logic [15:0] point_red;
	logic [15:0] point_green;
	logic [15:0] point_blue;
	logic [15:0] lookup_t;

	modport source (output valid, kind, point_index, point_position, point_red,
		point_green, point_blue, lookup_t, input ready);
	modport sink (input valid, kind, point_index, point_position, point_red,
		point_green, point_blue, lookup_t, output ready);
endinterface

FILE: src/crev_color_if.sv
// ----------------------------------------------------------------------------
// crev_color_if: result item channel
// Carries one interpolated rgb color with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface crev_color_if;
	logic        valid;
	logic        ready;
	logic [15:0] ramp_red;
	logic [15:0] ramp_green;
	logic [15:0] ramp_blue;

	modport source (output valid, ramp_red, ramp_green, ramp_blue, input ready);
	modport sink (input valid, ramp_red, ramp_green, ramp_blue, output ready);
endinterface

FILE: src/crev_ram.sv
// ----------------------------------------------------------------------------
// crev_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module crev_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

FILE: src/crev_div.sv
// ----------------------------------------------------------------------------
// crev_div: pipelined restoring divider
// Fraction quotient (rem << 16) / den for rem < den, two bits per stage.
// ----------------------------------------------------------------------------
module crev_div import crev_pkg::*; #(
	parameter int SIDE_W = 98
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_v,
	input  logic [U_W-1:0]    rem_in,
	input  logic [U_W-1:0]    den_in,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_v,
	output logic [U_W-1:0]    quo_out,
	output logic [SIDE_W-1:0] side_out
);

	localparam int STAGES = U_W / 2;

	logic              v_s   [0:STAGES];
	logic [U_W-1:0]    rem_s [0:STAGES];
	logic [U_W-1:0]    den_s [0:STAGES];
	logic [U_W-1:0]    quo_s [0:STAGES];
	logic [SIDE_W-1:0] side_s[0:STAGES];

	assign v_s[0]    = in_v;
	assign rem_s[0]  = rem_in;
	assign den_s[0]  = den_in;
	assign quo_s[0]  = '0;
	assign side_s[0] = side_in;

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		logic [U_W:0]   r2a;
		logic [U_W:0]   r2b;
		logic [U_W-1:0] ra;
		logic [U_W-1:0] rb;
		logic           qa;
		logic           qb;

		always_comb begin
			r2a = {rem_s[k], 1'b0};
			qa  = (r2a >= {1'b0, den_s[k]});
			ra  = qa ? U_W'(r2a - {1'b0, den_s[k]}) : r2a[U_W-1:0];
			r2b = {ra, 1'b0};
			qb  = (r2b >= {1'b0, den_s[k]});
			rb  = qb ? U_W'(r2b - {1'b0, den_s[k]}) : r2b[U_W-1:0];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= rb;
				den_s[k+1]  <= den_s[k];
				quo_s[k+1]  <= {quo_s[k][U_W-3:0], qa, qb};
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_v    = v_s[STAGES];
	assign quo_out  = quo_s[STAGES];
	assign side_out = side_s[STAGES];

endmodule

FILE: src/crev_shape.sv
// ----------------------------------------------------------------------------
// crev_shape: blend factor shaping
// Applies the selected easing curve to u, with sine from the quarter-wave table.
// ----------------------------------------------------------------------------
module crev_shape import crev_pkg::*; #(
	parameter int SIDE_W = 96
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_v,
	input  logic [U_W-1:0]    u,
	input  shape_ctl_t        ctl,
	input  logic [2:0]        mode,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_v,
	output logic [UF_W-1:0]   uf,
	output logic [SIDE_W-1:0] side_out
);

	logic              v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [U_W-1:0]    u_s1, u_s2, u_s3, u_s4;
	logic [UF_W-1:0]   w_s1, w_s2, w_s3;
	logic [UF_W-1:0]   f_s1;
	shape_ctl_t        ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic [SIDE_W-1:0] side_s1, side_s2, side_s3, side_s4, side_s5;
	logic [UF_W-1:0]   a_s2, diff_s2;
	logic [7:0]        fr_s2;
	logic [UF_W-1:0]   s_s3, s_s4;
	logic [UF_W-1:0]   sq_s4;
	logic [UF_W-1:0]   uf_s5;

	logic [UF_W-1:0]   w_c;
	logic              use_w;
	logic [8:0]        i0, i1;
	logic [UF_W-1:0]   ta, tb;
	logic [24:0]       ip;
	logic [UF_W-1:0]   x_c;
	logic [33:0]       sq_p;
	logic [UF_W-1:0]   uf_c;

	always_comb begin
		w_c   = Q16_ONE - {1'b0, u};
		use_w = (mode == MODE_BUMP || mode == MODE_SPIKE) && !ctl.up;
	end

	// table lookup, second entry clamps at the quarter-wave end
	always_comb begin
		i0 = f_s1[16:8];
		i1 = f_s1[16] ? i0 : i0 + 9'd1;
		ta = SINE_TAB[i0];
		tb = SINE_TAB[i1];
	end

	assign ip = diff_s2 * fr_s2;

	always_comb begin
		case (mode)
			MODE_EASE_UP:   x_c = {1'b0, u_s3};
			MODE_EASE_DOWN: x_c = w_s3;
			default:        x_c = s_s3;
		endcase
		sq_p = x_c * x_c;
	end

	always_comb begin
		case (mode)
			MODE_LINEAR:    uf_c = {1'b0, u_s4};
			MODE_EASE_UP:   uf_c = sq_s4;
			MODE_EASE_DOWN: uf_c = Q16_ONE - sq_s4;
			MODE_SMOOTH:    uf_c = sq_s4;
			MODE_BUMP:      uf_c = ctl_s4.up ? s_s4 : Q16_ONE - s_s4;
			MODE_SPIKE:     uf_c = ctl_s4.up ? s_s4 : Q16_ONE - s_s4;
			default:        uf_c = '0;
		endcase
		if (ctl_s4.zero)
			uf_c = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1    <= u;
			w_s1    <= w_c;
			f_s1    <= use_w ? w_c : {1'b0, u};
			ctl_s1  <= ctl;
			side_s1 <= side_in;

			a_s2    <= ta;
			diff_s2 <= (tb > ta) ? tb - ta : '0;
			fr_s2   <= f_s1[7:0];
			u_s2    <= u_s1;
			w_s2    <= w_s1;
			ctl_s2  <= ctl_s1;
			side_s2 <= side_s1;

			s_s3    <= a_s2 + UF_W'(ip >> 8);
			u_s3    <= u_s2;
			w_s3    <= w_s2;
			ctl_s3  <= ctl_s2;
			side_s3 <= side_s2;

			sq_s4   <= sq_p[32:16];
			s_s4    <= s_s3;
			u_s4    <= u_s3;
			ctl_s4  <= ctl_s3;
			side_s4 <= side_s3;

			uf_s5   <= uf_c;
			side_s5 <= side_s4;
		end
	end

	assign out_v    = v_s5;
	assign uf       = uf_s5;
	assign side_out = side_s5;

endmodule

FILE: src/crev_mix.sv
// ----------------------------------------------------------------------------
// crev_mix: color mixer
// Blends the bracketing colors per channel by the shaped factor.
// ----------------------------------------------------------------------------
module crev_mix import crev_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_v,
	input  logic [UF_W-1:0] uf,
	input  rgb_t            c0,
	input  rgb_t            c1,
	output logic            out_v,
	output rgb_t            rgb
);

	logic              v_s1, v_s2;
	logic [32:0]       pa_s1 [3];
	logic [32:0]       pb_s1 [3];
	logic [CHAN_W-1:0] ch0 [3];
	logic [CHAN_W-1:0] ch1 [3];
	logic [UF_W-1:0]   uinv;
	logic [33:0]       sum [3];

	always_comb begin
		ch0[0] = c0.r;
		ch0[1] = c0.g;
		ch0[2] = c0.b;
		ch1[0] = c1.r;
		ch1[1] = c1.g;
		ch1[2] = c1.b;
		uinv   = Q16_ONE - uf;
		for (int c = 0; c < 3; c++)
			sum[c] = {1'b0, pa_s1[c]} + {1'b0, pb_s1[c]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				pa_s1[c] <= ch0[c] * uinv;
				pb_s1[c] <= ch1[c] * uf;
			end
			rgb.r <= sum[0][31:16];
			rgb.g <= sum[1][31:16];
			rgb.b <= sum[2][31:16];
		end
	end

	assign out_v = v_s2;

endmodule

FILE: src/color_ramp_evaluator_unit.sv
// ----------------------------------------------------------------------------
// color_ramp_evaluator_unit: color ramp evaluator top level
// Stores control points and returns the shaped, mixed color at a position.
// ----------------------------------------------------------------------------
// throughput: one item per cycle while the result register is free; a point write waits
//   while an evaluate sits in the bracket search stage, which reads the point store
// point writes give no result item and leave the pipeline at once
// reset: count 1, mode linear, pipeline empty; point store undefined until written
module color_ramp_evaluator_unit import crev_pkg::*; #(
	parameter int MAX_POINTS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [3:0]  cfg_wdata,
	crev_lookup_if.sink lookup,
	crev_color_if.source color
);

	localparam int IDX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int SIDE_W = $bits(div_side_t);

	logic [3:0]       count_q;
	logic [2:0]       mode_q;
	logic [POS_W-1:0] pos_q [MAX_POINTS];

	logic             adv, acc, wr_en;
	logic [IDX_W-1:0] wr_addr;
	rgb_t             wr_rgb;

	logic             s1_v;
	logic [POS_W-1:0] t_s1;

	logic             prev_f, next_f;
	logic [IDX_W-1:0] prev_i, next_i, a_idx, b_idx;
	logic [POS_W-1:0] prev_p, next_p;
	logic             in_use [MAX_POINTS];
	logic [MAX_POINTS-1:0] above, prev_sel, next_sel;

	logic             s2_v, s2_edge;
	logic [POS_W-1:0] t_s2, p0_s2, p1_s2;
	rgb_t             col_a, col_b;
	logic [17:0]      lum_a, lum_b;
	div_side_t        dside;
	logic [SIDE_W-1:0] dside_out;
	div_side_t        dres;
	logic             dv;
	logic [U_W-1:0]   quo;

	logic             sv;
	logic [UF_W-1:0]  uf;
	logic [2*$bits(rgb_t)-1:0] sside;
	rgb_t             mix_c0, mix_c1;
	logic             out_v;
	rgb_t             out_rgb;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 4'd1;
			mode_q  <= MODE_LINEAR;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POINT_COUNT: count_q <= cfg_wdata;
				REG_INTERP_MODE: mode_q  <= cfg_wdata[2:0];
				default: ;
			endcase
		end
	end

	// whole pipeline moves when the result register is free
	assign adv          = !out_v || color.ready;
	assign lookup.ready = adv && !(s1_v && !lookup.kind);
	assign acc          = lookup.valid && lookup.ready;
	assign wr_en        = acc && !lookup.kind && (int'(lookup.point_index) < MAX_POINTS);
	assign wr_addr      = IDX_W'(lookup.point_index);
	assign wr_rgb       = '{r: lookup.point_red, g: lookup.point_green, b: lookup.point_blue};

	always_ff @(posedge clk) begin
		if (wr_en)
			pos_q[wr_addr] <= lookup.point_position;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
			s2_v <= 1'b0;
		end else if (adv) begin
			s1_v <= acc && lookup.kind;
			s2_v <= s1_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s1    <= lookup.lookup_t;
			t_s2    <= t_s1;
			p0_s2   <= prev_p;
			p1_s2   <= next_p;
			s2_edge <= !(prev_f && next_f);
		end
	end

	// bracket search: last point at or below t, first point above t
	// pairwise compares in parallel, ties ordered by slot
	always_comb begin
		for (int i = 0; i < MAX_POINTS; i++) begin
			in_use[i] = (i == 0) || (int'(count_q) > i);
			above[i]  = pos_q[i] > t_s1;
		end
		for (int i = 0; i < MAX_POINTS; i++) begin
			prev_sel[i] = in_use[i] && !above[i];
			next_sel[i] = in_use[i] && above[i];
			for (int j = 0; j < MAX_POINTS; j++) begin
				if (j != i && in_use[j]) begin
					if (above[j] && (pos_q[j] < pos_q[i] || (pos_q[j] == pos_q[i] && j < i)))
						next_sel[i] = 1'b0;
					if (!above[j] && (pos_q[j] > pos_q[i] || (pos_q[j] == pos_q[i] && j > i)))
						prev_sel[i] = 1'b0;
				end
			end
		end
		prev_f = |prev_sel;
		next_f = |next_sel;
		prev_i = '0;
		next_i = '0;
		prev_p = '0;
		next_p = '0;
		for (int i = 0; i < MAX_POINTS; i++) begin
			if (prev_sel[i]) begin
				prev_i = prev_i | IDX_W'(i);
				prev_p = prev_p | pos_q[i];
			end
			if (next_sel[i]) begin
				next_i = next_i | IDX_W'(i);
				next_p = next_p | pos_q[i];
			end
		end
		a_idx = prev_f ? prev_i : next_i;
		b_idx = next_f ? next_i : prev_i;
	end

	crev_ram #(.WIDTH($bits(rgb_t)), .DEPTH(MAX_POINTS)) u_ram_a (
		.clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(wr_rgb),
		.re(adv), .raddr(a_idx), .rdata(col_a)
	);

	crev_ram #(.WIDTH($bits(rgb_t)), .DEPTH(MAX_POINTS)) u_ram_b (
		.clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(wr_rgb),
		.re(adv), .raddr(b_idx), .rdata(col_b)
	);

	always_comb begin
		lum_a = 18'(col_a.r) + 18'(col_a.g) + 18'(col_a.b);
		lum_b = 18'(col_b.r) + 18'(col_b.g) + 18'(col_b.b);
		dside.ctl.zero = s2_edge;
		dside.ctl.up   = (mode_q == MODE_BUMP) ? (lum_a < lum_b) : (lum_a > lum_b);
		dside.c0       = col_a;
		dside.c1       = col_b;
	end

	crev_div #(.SIDE_W(SIDE_W)) u_div (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_v(s2_v),
		.rem_in(t_s2 - p0_s2), .den_in(p1_s2 - p0_s2), .side_in(dside),
		.out_v(dv), .quo_out(quo), .side_out(dside_out)
	);

	assign dres = div_side_t'(dside_out);

	crev_shape #(.SIDE_W(2*$bits(rgb_t))) u_shape (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_v(dv), .u(quo),
		.ctl(dres.ctl), .mode(mode_q), .side_in({dres.c0, dres.c1}),
		.out_v(sv), .uf(uf), .side_out(sside)
	);

	assign mix_c0 = sside[2*$bits(rgb_t)-1:$bits(rgb_t)];
	assign mix_c1 = sside[$bits(rgb_t)-1:0];

	crev_mix u_mix (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_v(sv), .uf(uf),
		.c0(mix_c0), .c1(mix_c1), .out_v(out_v), .rgb(out_rgb)
	);

	assign color.valid      = out_v;
	assign color.ramp_red   = out_rgb.r;
	assign color.ramp_green = out_rgb.g;
	assign color.ramp_blue  = out_rgb.b;

	// no point write lands while an evaluate is reading the store
	a_no_write_hazard: assert property (@(posedge clk) disable iff (!arst_n)
		lookup.valid && lookup.ready && !lookup.kind |-> !s1_v)
		else $error("point write accepted during bracket search");

	// a stalled search stage keeps its item
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_v && !adv |=> s1_v)
		else $error("item lost in search stage during stall");

	// an interior bracket always has a positive span
	a_span: assert property (@(posedge clk) disable iff (!arst_n)
		s2_v && !s2_edge |-> p1_s2 > p0_s2)
		else $error("bracket span not positive");

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the color ramp evaluator
// Loads control points, evaluates the ramp under every shaping mode and many
// point counts, and checks each returned color against an in-bench predictor
// with random idling on both channels and one long result stall.
// ----------------------------------------------------------------------------
module tb_top;
	import crev_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		bit        kind;
		bit [2:0]  slot;
		bit [15:0] pos;
		bit [15:0] red;
		bit [15:0] green;
		bit [15:0] blue;
		bit [15:0] t;
	} ramp_req_t;

	localparam bit KIND_WRITE = 1'b0;
	localparam bit KIND_EVAL  = 1'b1;
	localparam int NUM_SLOTS  = 8;
	localparam int CYCLE_LIMIT = 1000000;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_index;
	logic [3:0] cfg_wdata;

	crev_lookup_if lookup();
	crev_color_if  color();

	color_ramp_evaluator_unit uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .lookup(lookup), .color(color)
	);

	// predictor state
	bit [15:0]   slot_pos [NUM_SLOTS];
	rgb_t        slot_col [NUM_SLOTS];
	bit [3:0]    count_reg;
	bit [2:0]    mode_reg;
	bit [16:0]   sin_tab [0:256];

	ramp_req_t   feed_q[$];
	rgb_t        color_q[$];
	int          mismatches;
	bit          no_idle;
	bit          hold_phase;
	bit          hold_ready;
	int          send_gap;
	int          recv_gap;
	longint      cycles;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void fill_sine();
		longint unsigned x, x2, term, sum, v;
		for (int k = 0; k <= 256; k++) begin
			x = (64'd1686629713 * k) / 256;
			x2 = (x * x) >> 30;
			term = x;
			sum = x;
			for (int n = 1; n <= 7; n++) begin
				term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
				if (n % 2 == 1)
					sum = (sum >= term) ? sum - term : 0;
				else
					sum = sum + term;
			end
			v = (sum + 8192) >> 14;
			sin_tab[k] = (v > 65536) ? 17'h10000 : v[16:0];
		end
	endfunction

	function automatic longint unsigned quarter_sin(longint unsigned f);
		longint unsigned p, i, fr, a, b;
		p = f * 256;
		i = p >> 16;
		fr = p & 16'hFFFF;
		if (i >= 256)
			return sin_tab[256];
		a = sin_tab[i];
		b = sin_tab[i + 1];
		if (b <= a)
			return a;
		return a + (((b - a) * fr) >> 16);
	endfunction

	function automatic rgb_t ramp_color(bit [15:0] t);
		int order [NUM_SLOTS];
		int n, r, nxt, a, b;
		longint unsigned u, w, q, lc, ln, m;
		logic [15:0] c0 [3];
		logic [15:0] c1 [3];
		rgb_t res;
		n = count_reg;
		if (n < 1) n = 1;
		if (n > NUM_SLOTS) n = NUM_SLOTS;
		for (int i = 0; i < n; i++) begin
			r = 0;
			for (int j = 0; j < n; j++)
				if (slot_pos[j] < slot_pos[i] || (slot_pos[j] == slot_pos[i] && j < i))
					r++;
			order[r] = i;
		end
		nxt = n;
		for (int i = 0; i < n; i++)
			if (t < slot_pos[order[i]]) begin
				nxt = i;
				break;
			end
		if (nxt == 0)
			return slot_col[order[0]];
		if (nxt >= n)
			return slot_col[order[n - 1]];
		a = order[nxt - 1];
		b = order[nxt];
		u = (longint'(t - slot_pos[a]) << 16) / longint'(slot_pos[b] - slot_pos[a]);
		lc = slot_col[a].r + slot_col[a].g + slot_col[a].b;
		ln = slot_col[b].r + slot_col[b].g + slot_col[b].b;
		case (mode_reg)
			MODE_LINEAR: ;
			MODE_EASE_UP: u = (u * u) >> 16;
			MODE_EASE_DOWN: begin
				w = 65536 - u;
				u = 65536 - ((w * w) >> 16);
			end
			MODE_SMOOTH: begin
				q = quarter_sin(u);
				u = (q * q) >> 16;
			end
			MODE_BUMP, MODE_SPIKE: begin
				if ((mode_reg == MODE_BUMP) ? (lc < ln) : (lc > ln))
					u = quarter_sin(u);
				else
					u = 65536 - quarter_sin(65536 - u);
			end
			default: u = 0;
		endcase
		c0 = '{slot_col[a].r, slot_col[a].g, slot_col[a].b};
		c1 = '{slot_col[b].r, slot_col[b].g, slot_col[b].b};
		for (int i = 0; i < 3; i++) begin
			m = (longint'(c0[i]) * (65536 - u) + longint'(c1[i]) * u) >> 16;
			if (i == 0) res.r = m[15:0];
			else if (i == 1) res.g = m[15:0];
			else res.b = m[15:0];
		end
		return res;
	endfunction

	// sender: drives items from feed_q, predicts on acceptance
	always @(posedge clk) begin
		if (!arst_n) begin
			lookup.valid <= 1'b0;
		end else begin
			if (lookup.valid && lookup.ready) begin
				if (lookup.kind == KIND_WRITE) begin
					slot_pos[lookup.point_index] = lookup.point_position;
					slot_col[lookup.point_index] = '{lookup.point_red, lookup.point_green,
						lookup.point_blue};
				end else begin
					color_q.push_back(ramp_color(lookup.lookup_t));
				end
			end
			if (lookup.valid && !lookup.ready) begin
				// hold the offered item
			end else if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				lookup.valid <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 9) == 0) begin
				send_gap <= $urandom_range(0, 14);
				lookup.valid <= 1'b0;
			end else if (feed_q.size() > 0) begin
				ramp_req_t it;
				it = feed_q.pop_front();
				lookup.valid <= 1'b1;
				lookup.kind <= it.kind;
				lookup.point_index <= it.slot;
				lookup.point_position <= it.pos;
				lookup.point_red <= it.red;
				lookup.point_green <= it.green;
				lookup.point_blue <= it.blue;
				lookup.lookup_t <= it.t;
			end else begin
				lookup.valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls, checks each color item
	always @(posedge clk) begin
		if (!arst_n) begin
			color.ready <= 1'b0;
		end else begin
			if (color.valid && color.ready) begin
				if (color_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected color item %h %h %h", color.ramp_red,
							color.ramp_green, color.ramp_blue);
				end else begin
					rgb_t e;
					e = color_q.pop_front();
					if (color.ramp_red !== e.r || color.ramp_green !== e.g ||
						color.ramp_blue !== e.b) begin
						mismatches++;
						if (mismatches <= 10)
							$display("color mismatch: expected %h %h %h got %h %h %h",
								e.r, e.g, e.b, color.ramp_red, color.ramp_green,
								color.ramp_blue);
					end
				end
			end
			if (hold_ready) begin
				color.ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				color.ready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 9) == 0) begin
				recv_gap <= $urandom_range(0, 14);
				color.ready <= 1'b0;
			end else begin
				color.ready <= 1'b1;
			end
		end
	end

	// long result stall while items keep coming
	initial begin
		hold_ready = 1'b0;
		wait (hold_phase);
		repeat (20) @(posedge clk);
		hold_ready <= 1'b1;
		repeat (400) @(posedge clk);
		hold_ready <= 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic bit [15:0] pick_pos();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return slot_pos[$urandom_range(0, NUM_SLOTS - 1)];
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	function automatic bit [15:0] pick_chan();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	task automatic add_write(bit [2:0] s, bit [15:0] p, bit [15:0] r, bit [15:0] g,
		bit [15:0] b);
		feed_q.push_back('{KIND_WRITE, s, p, r, g, b, $urandom_range(0, 65535)});
	endtask

	task automatic add_eval(bit [15:0] t);
		feed_q.push_back('{KIND_EVAL, $urandom_range(0, 7), $urandom_range(0, 65535),
			$urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535), t});
	endtask

	task automatic add_random(int num);
		bit [15:0] c;
		for (int i = 0; i < num; i++) begin
			if ($urandom_range(0, 4) == 0) begin
				c = pick_chan();
				// sometimes a gray point so luminances tie
				if ($urandom_range(0, 3) == 0)
					add_write($urandom_range(0, 7), pick_pos(), c, c, c);
				else
					add_write($urandom_range(0, 7), pick_pos(), pick_chan(), pick_chan(),
						pick_chan());
			end else begin
				add_eval($urandom_range(0, 3) == 0 ? pick_pos() : 16'($urandom_range(0, 65535)));
			end
		end
	endtask

	task automatic wait_idle();
		while (feed_q.size() > 0 || lookup.valid || color_q.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_reg(logic idx, bit [3:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_POINT_COUNT)
			count_reg = val;
		else
			mode_reg = val[2:0];
		@(posedge clk);
	endtask

	initial begin
		int counts [6] = '{8, 0, 1, 2, 15, 5};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_POINT_COUNT;
		cfg_wdata = '0;
		lookup.valid = 1'b0;
		lookup.kind = KIND_WRITE;
		lookup.point_index = '0;
		lookup.point_position = '0;
		lookup.point_red = '0;
		lookup.point_green = '0;
		lookup.point_blue = '0;
		lookup.lookup_t = '0;
		color.ready = 1'b0;
		mismatches = 0;
		no_idle = 1'b0;
		hold_phase = 1'b0;
		send_gap = 0;
		recv_gap = 0;
		cycles = 0;
		count_reg = 4'd1;
		mode_reg = MODE_LINEAR;
		fill_sine();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every slot written before any evaluate; equal positions in slots 2 and 3
		add_write(0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		add_write(1, 16'h2000, 16'hFFFF, 16'h0000, 16'h8000);
		add_write(2, 16'h4000, 16'h1234, 16'hABCD, 16'h5555);
		add_write(3, 16'h4000, 16'hAAAA, 16'h0F0F, 16'hF0F0);
		add_write(4, 16'h9000, 16'h4000, 16'h4000, 16'h4000);
		add_write(5, 16'h7000, 16'h8000, 16'hFFFF, 16'h0001);
		add_write(6, 16'hC000, 16'h0000, 16'hFFFF, 16'hFFFF);
		add_write(7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		// single point: every t gives slot 0
		add_eval(16'h0000);
		add_eval(16'hFFFF);
		wait_idle();
		set_reg(REG_POINT_COUNT, 4'd8);
		set_reg(REG_INTERP_MODE, MODE_LINEAR);
		add_eval(16'h0000);
		add_eval(16'h0001);
		add_eval(16'h1FFF);
		add_eval(16'h4000);
		add_eval(16'h3FFF);
		add_eval(16'h8000);
		add_eval(16'hFFFE);
		add_eval(16'hFFFF);
		// slot 0 moved up to 0x1000 so t below the first point is reachable
		add_write(0, 16'h1000, 16'h0101, 16'h0202, 16'h0303);
		add_eval(16'h0000);
		add_eval(16'h0FFF);
		wait_idle();

		for (int m = 0; m < 8; m++) begin
			set_reg(REG_INTERP_MODE, 4'(m));
			if (m == 2)
				hold_phase = 1'b1;
			add_eval(16'h0000);
			add_eval(16'h5000);
			add_eval(16'hFFFF);
			add_random(m == 2 ? 200 : 120);
			wait_idle();
		end
		for (int c = 0; c < 6; c++) begin
			set_reg(REG_POINT_COUNT, 4'(counts[c]));
			set_reg(REG_INTERP_MODE, 4'($urandom_range(0, 7)));
			if (c == 5)
				no_idle = 1'b1;
			add_random(120);
			wait_idle();
		end
		set_reg(REG_INTERP_MODE, MODE_SPIKE);
		set_reg(REG_POINT_COUNT, 4'd8);
		add_random(60);
		wait_idle();

		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
